FILE: sv/rbe_pkg.sv
// Shared types, constants and helpers for the ray/box entry point block.
// Used by rbe_face, rbe_pick and the top unit; no dependencies.
package rbe_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_AXES      = 3;
	localparam int NUM_FACES     = 6;
	localparam int COORD_W       = 32;
	localparam int ORIG_W        = 33;
	localparam int SIZE_W        = 31;
	localparam int T_W           = 31;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_OFFSET_X = 3'd0;
	localparam reg_idx_t REG_OFFSET_Y = 3'd1;
	localparam reg_idx_t REG_OFFSET_Z = 3'd2;
	localparam reg_idx_t REG_SIZE_X   = 3'd3;
	localparam reg_idx_t REG_SIZE_Y   = 3'd4;
	localparam reg_idx_t REG_SIZE_Z   = 3'd5;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

	typedef logic [NUM_AXES-1:0][ORIG_W-1:0]  orig_vec_t;
	typedef logic [NUM_AXES-1:0][COORD_W-1:0] dir_vec_t;
	typedef logic [NUM_AXES-1:0][SIZE_W-1:0]  size_vec_t;

	// one face candidate: usable flag, distance and hit point
	typedef struct packed {
		logic                             ok;
		logic [T_W-1:0]                   t;
		logic [NUM_AXES-1:0][COORD_W-1:0] p;
	} cand_t;

	// earlier candidate wins ties
	function automatic cand_t pick_first(cand_t l, cand_t r);
		cand_t res;
		res = (l.ok && (!r.ok || l.t <= r.t)) ? l : r;
		return res;
	endfunction

endpackage

FILE: sv/rbe_if.sv
// Request channels of the ray/box entry point block: ray in, result out.
// Depends on nothing.
interface rbe_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] orig_x;
	logic signed [31:0] orig_y;
	logic signed [31:0] orig_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (output valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rbe_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] entry_x;
	logic signed [31:0] entry_y;
	logic signed [31:0] entry_z;

	modport source (output valid, hit, entry_x, entry_y, entry_z, input ready);
	modport sink (input valid, hit, entry_x, entry_y, entry_z, output ready);
endinterface

FILE: sv/rbe_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses no package items; stalls with the shared pipeline enable.
module rbe_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	logic [DEN_W-1:0] rem_n [NUM_W];
	logic [NUM_W-1:0] num_n [NUM_W];
	logic [NUM_W-1:0] quo_n [NUM_W];
	logic [DEN_W-1:0] den_n [NUM_W];

	always_comb begin
		logic [DEN_W-1:0] rem_i;
		logic [NUM_W-1:0] num_i;
		logic [NUM_W-1:0] quo_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W:0]   trial;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				rem_i = '0;
				num_i = num;
				quo_i = '0;
				den_i = den;
			end else begin
				rem_i = rem_s[k-1];
				num_i = num_s[k-1];
				quo_i = quo_s[k-1];
				den_i = den_s[k-1];
			end
			trial = {rem_i, num_i[NUM_W-1]};
			if (trial >= {1'b0, den_i}) begin
				rem_n[k] = DEN_W'(trial - {1'b0, den_i});
				quo_n[k] = {quo_i[NUM_W-2:0], 1'b1};
			end else begin
				rem_n[k] = trial[DEN_W-1:0];
				quo_n[k] = {quo_i[NUM_W-2:0], 1'b0};
			end
			num_n[k] = {num_i[NUM_W-2:0], 1'b0};
			den_n[k] = den_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k] <= rem_n[k];
				num_s[k] <= num_n[k];
				quo_s[k] <= quo_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quo = quo_s[NUM_W-1];

endmodule

FILE: sv/rbe_delay.sv
// Delay line that carries the valid bit and side data past the dividers.
// Uses no package items.
module rbe_delay #(
	parameter int DEPTH = 49,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vin,
	input  logic [WIDTH-1:0] din,
	output logic             vout,
	output logic [WIDTH-1:0] dout
);

	logic [DEPTH-1:0] v_s;
	logic [WIDTH-1:0] d_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DEPTH-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				d_s[k] <= d_s[k-1];
			end
		end
	end

	assign vout = v_s[DEPTH-1];
	assign dout = d_s[DEPTH-1];

endmodule

FILE: sv/rbe_face.sv
// One box face: hit point from distance t (multiply stage, add/check stage).
// Depends on rbe_pkg.
module rbe_face #(
	parameter int FRAC_BITS = rbe_pkg::FRAC_BITS_DEF,
	parameter int AXIS      = 0,
	parameter int HIGH      = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    ok,
	input  logic [rbe_pkg::T_W-1:0] t,
	input  rbe_pkg::orig_vec_t      orig,
	input  rbe_pkg::dir_vec_t       dir,
	input  rbe_pkg::size_vec_t      size,
	output rbe_pkg::cand_t          cand
);
	import rbe_pkg::*;

	localparam int PROD_W = 2 * COORD_W;
	localparam int SUM_W  = PROD_W + 1 - FRAC_BITS;

	logic signed [PROD_W-1:0] prod_s1 [NUM_AXES];
	logic                     ok_s1;
	logic [T_W-1:0]           t_s1;
	orig_vec_t                orig_s1;
	cand_t                    cand_s2;
	cand_t                    cand_c;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < NUM_AXES; b++) begin
				if (b != AXIS) begin
					prod_s1[b] <= $signed(dir[b]) * $signed({1'b0, t});
				end else begin
					prod_s1[b] <= '0;
				end
			end
			ok_s1   <= ok;
			t_s1    <= t;
			orig_s1 <= orig;
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] pw;
		logic                    in_box;
		in_box = 1'b1;
		for (int b = 0; b < NUM_AXES; b++) begin
			if (b == AXIS) begin
				pw = (HIGH != 0) ? $signed(SUM_W'(size[b])) : '0;
			end else begin
				// floor(d*t / 2^F) is an arithmetic shift
				pw = $signed(SUM_W'($signed(orig_s1[b])))
					+ $signed(SUM_W'($signed(prod_s1[b][PROD_W-1:FRAC_BITS])));
			end
			if (pw[SUM_W-1] || (pw > $signed(SUM_W'(size[b])))) begin
				in_box = 1'b0;
			end
			cand_c.p[b] = pw[COORD_W-1:0];
		end
		cand_c.ok = ok_s1 && in_box;
		cand_c.t  = t_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cand_s2 <= cand_c;
		end
	end

	assign cand = cand_s2;

endmodule

FILE: sv/rbe_pick.sv
// First two levels of the nearest-face selection tree over six faces.
// Depends on rbe_pkg.
module rbe_pick (
	input  logic           clk,
	input  logic           en,
	input  rbe_pkg::cand_t cand [rbe_pkg::NUM_FACES],
	output rbe_pkg::cand_t near_lo,
	output rbe_pkg::cand_t near_hi
);
	import rbe_pkg::*;

	cand_t x_s1, y_s1, z_s1;
	cand_t xy_s2, z_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= pick_first(cand[0], cand[1]);
			y_s1  <= pick_first(cand[2], cand[3]);
			z_s1  <= pick_first(cand[4], cand[5]);
			xy_s2 <= pick_first(x_s1, y_s1);
			z_s2  <= z_s1;
		end
	end

	assign near_lo = xy_s2;
	assign near_hi = z_s2;

endmodule

FILE: sv/ray_box_entry_point_unit.sv
// Ray entry point into an axis-aligned box, signed fixed point.
// Depends on rbe_pkg, rbe_if, rbe_div, rbe_delay, rbe_face, rbe_pick.
//
// Rays come in on the ray channel (origin and direction), one result per
// ray leaves on the res channel: hit flag and entry point in box space,
// zero when the ray misses. Box offset and size are set on the cfg write
// port (index 0..2 offset x/y/z, 3..5 size x/y/z, others ignored); write
// them only while no ray is in flight.
// Throughput: one ray per cycle while the output is not stalled. The
// format is Q16.16 at the default FRACTION_BITS; the six parallel
// divider pipelines have 33 + FRACTION_BITS stages, one quotient bit each,
// plus input, operand, multiply, point check, selection and output stages.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls every stage holds and ray.ready is low, so no
// request is lost or repeated. Reset clears all valid bits and sets the
// offsets to zero and sizes to 65536 (1.0 at Q16.16).
module ray_box_entry_point_unit #(
	parameter int FRACTION_BITS = rbe_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  rbe_pkg::reg_idx_t           cfg_idx,
	input  logic [rbe_pkg::COORD_W-1:0] cfg_data,
	rbe_ray_if.sink                     ray,
	rbe_res_if.source                   res
);
	import rbe_pkg::*;

	localparam int NUM_W  = ORIG_W + FRACTION_BITS;
	localparam int DIFF_W = ORIG_W + 1;
	localparam int SIDE_W = NUM_AXES * (ORIG_W + COORD_W) + 2 * NUM_FACES;

	logic [COORD_W-1:0] offset_q [NUM_AXES];
	size_vec_t          size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				offset_q[a] <= '0;
				size_q[a]   <= SIZE_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OFFSET_X: offset_q[0] <= cfg_data;
				REG_OFFSET_Y: offset_q[1] <= cfg_data;
				REG_OFFSET_Z: offset_q[2] <= cfg_data;
				REG_SIZE_X:   size_q[0]   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:   size_q[1]   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:   size_q[2]   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en        = !res.valid || res.ready;
	assign ray.ready = en;

	// stage 1: origin into box space
	logic      v_s1;
	orig_vec_t orig_s1;
	dir_vec_t  dir_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orig_s1[0] <= ORIG_W'(ray.orig_x) + ORIG_W'($signed(offset_q[0]));
			orig_s1[1] <= ORIG_W'(ray.orig_y) + ORIG_W'($signed(offset_q[1]));
			orig_s1[2] <= ORIG_W'(ray.orig_z) + ORIG_W'($signed(offset_q[2]));
			dir_s1[0]  <= ray.dir_x;
			dir_s1[1]  <= ray.dir_y;
			dir_s1[2]  <= ray.dir_z;
		end
	end

	// stage 2: per-face divider operands as magnitudes plus sign
	logic                 v_s2;
	orig_vec_t            orig_s2;
	dir_vec_t             dir_s2;
	logic [NUM_FACES-1:0] neg_s2;
	logic [NUM_FACES-1:0] dz_s2;
	logic [NUM_W-1:0]     num_s2 [NUM_FACES];
	logic [COORD_W-1:0]   den_s2 [NUM_FACES];

	logic [NUM_W-1:0]     num_c [NUM_FACES];
	logic [COORD_W-1:0]   den_c [NUM_FACES];
	logic [NUM_FACES-1:0] neg_c;
	logic [NUM_FACES-1:0] dz_c;

	always_comb begin
		logic [DIFF_W-1:0]  diff;
		logic [DIFF_W-1:0]  mag;
		logic [COORD_W-1:0] d;
		for (int f = 0; f < NUM_FACES; f++) begin
			d    = dir_s1[f/2];
			diff = ((f % 2) != 0) ? DIFF_W'(size_q[f/2]) : '0;
			diff = diff - DIFF_W'($signed(orig_s1[f/2]));
			mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
			num_c[f] = {mag[ORIG_W-1:0], {FRACTION_BITS{1'b0}}};
			den_c[f] = d[COORD_W-1] ? COORD_W'(-d) : d;
			neg_c[f] = diff[DIFF_W-1] ^ d[COORD_W-1];
			dz_c[f]  = (d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orig_s2 <= orig_s1;
			dir_s2  <= dir_s1;
			neg_s2  <= neg_c;
			dz_s2   <= dz_c;
			for (int f = 0; f < NUM_FACES; f++) begin
				num_s2[f] <= num_c[f];
				den_s2[f] <= den_c[f];
			end
		end
	end

	// dividers and side data
	logic [NUM_W-1:0]     quo [NUM_FACES];
	logic                 v_dv;
	logic [SIDE_W-1:0]    side_dv;
	orig_vec_t            orig_dv;
	dir_vec_t             dir_dv;
	logic [NUM_FACES-1:0] neg_dv;
	logic [NUM_FACES-1:0] dz_dv;

	for (genvar f = 0; f < NUM_FACES; f++) begin : g_div
		rbe_div #(
			.NUM_W(NUM_W),
			.DEN_W(COORD_W)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s2[f]),
			.den (den_s2[f]),
			.quo (quo[f])
		);
	end

	rbe_delay #(
		.DEPTH(NUM_W),
		.WIDTH(SIDE_W)
	) u_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s2),
		.din    ({orig_s2, dir_s2, neg_s2, dz_s2}),
		.vout   (v_dv),
		.dout   (side_dv)
	);

	assign {orig_dv, dir_dv, neg_dv, dz_dv} = side_dv;

	// saturate distance; negative distances are dropped
	logic [T_W-1:0]       t_c  [NUM_FACES];
	logic [NUM_FACES-1:0] ok_c;

	always_comb begin
		for (int f = 0; f < NUM_FACES; f++) begin
			t_c[f]  = (quo[f][NUM_W-1:T_W] != '0) ? {T_W{1'b1}} : quo[f][T_W-1:0];
			ok_c[f] = !dz_dv[f] && !(neg_dv[f] && (quo[f] != '0));
		end
	end

	cand_t cand [NUM_FACES];

	for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
		rbe_face #(
			.FRAC_BITS(FRACTION_BITS),
			.AXIS     (f / 2),
			.HIGH     (f % 2)
		) u_face (
			.clk  (clk),
			.en   (en),
			.ok   (ok_c[f]),
			.t    (t_c[f]),
			.orig (orig_dv),
			.dir  (dir_dv),
			.size (size_q),
			.cand (cand[f])
		);
	end

	cand_t near_lo, near_hi;

	rbe_pick u_pick (
		.clk     (clk),
		.en      (en),
		.cand    (cand),
		.near_lo (near_lo),
		.near_hi (near_hi)
	);

	// valid bits for the face and selection stages
	logic fv_s1, fv_s2, pv_s1, pv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1     <= 1'b0;
			fv_s2     <= 1'b0;
			pv_s1     <= 1'b0;
			pv_s2     <= 1'b0;
			res.valid <= 1'b0;
		end else if (en) begin
			fv_s1     <= v_dv;
			fv_s2     <= fv_s1;
			pv_s1     <= fv_s2;
			pv_s2     <= pv_s1;
			res.valid <= pv_s2;
		end
	end

	cand_t best;
	assign best = pick_first(near_lo, near_hi);

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit     <= best.ok;
			res.entry_x <= best.ok ? best.p[0] : '0;
			res.entry_y <= best.ok ? best.p[1] : '0;
			res.entry_z <= best.ok ? best.p[2] : '0;
		end
	end

endmodule
